/* design/tfcd_pkg.sv */
// ----------------------------------------------------------------------------
// tfcd_pkg
// Shared types, register indexes and defaults for the tiled frame change
// detector.
// ----------------------------------------------------------------------------
package tfcd_pkg;

	localparam int MAX_THUMB_WIDTH  = 64;
	localparam int MAX_THUMB_HEIGHT = 64;
	localparam int TILES_X          = 8;
	localparam int TILES_Y          = 8;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int SIZE_W     = 7;
	localparam int THR_W      = 16;
	localparam int DIFF_W     = 10;

	localparam logic [CFG_IDX_W-1:0] REG_THUMB_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THUMB_HEIGHT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DUP_THRESHOLD = 2'd2;

	localparam logic [SIZE_W-1:0] THUMB_WIDTH_RST   = 7'd64;
	localparam logic [SIZE_W-1:0] THUMB_HEIGHT_RST  = 7'd64;
	localparam logic [THR_W-1:0]  DUP_THRESHOLD_RST = 16'd256;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic        is_duplicate;
		logic        was_compared;
		logic [15:0] max_tile_diff;
	} result_t;

	typedef enum logic [2:0] {
		ST_RUN,
		ST_DRAIN,
		ST_RD,
		ST_LD,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

/* design/tiled_frame_change_detector_core.sv */
// ----------------------------------------------------------------------------
// tiled_frame_change_detector_core
// Compares each thumbnail pixel with the stored previous frame, sums absolute
// differences per tile and reports the largest tile average at frame end.
//
//   channel   dir   handshake              payload
//   in        in    in_valid / in_ready    in_data  (pixel_t)
//   out       out   out_valid / out_ready  out_data (result_t)
//   cfg       in    cfg_we                 cfg_index, cfg_wdata
//
// One pixel per cycle while a frame streams in. After the last pixel the
// block walks the tile memory: per non-empty tile a read state, a load
// state and a run of the shared restoring divider; per empty tile only the
// read and load states. in_ready is low during that walk.
// The result sits in an output register; the next frame streams in while
// it waits. No clearing pass after reset; tile memory uses valid bits.
// ----------------------------------------------------------------------------
module tiled_frame_change_detector_core #(
	parameter int MaxThumbWidth  = tfcd_pkg::MAX_THUMB_WIDTH,
	parameter int MaxThumbHeight = tfcd_pkg::MAX_THUMB_HEIGHT,
	parameter int TilesX         = tfcd_pkg::TILES_X,
	parameter int TilesY         = tfcd_pkg::TILES_Y
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  tfcd_pkg::pixel_t                  in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output tfcd_pkg::result_t                 out_data,
	input  logic                              cfg_we,
	input  logic [tfcd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tfcd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import tfcd_pkg::*;

	localparam int NT     = TilesX * TilesY;
	localparam int TW     = (NT > 1) ? $clog2(NT) : 1;
	localparam int TXW    = (TilesX > 1) ? $clog2(TilesX) : 1;
	localparam int TYW    = (TilesY > 1) ? $clog2(TilesY) : 1;
	localparam int CW     = $clog2(MaxThumbWidth + 1);
	localparam int RW     = $clog2(MaxThumbHeight + 1);
	localparam int COLW   = $clog2(MaxThumbWidth);
	localparam int ROWW   = $clog2(MaxThumbHeight);
	localparam int AW     = $clog2(MaxThumbWidth * MaxThumbHeight);
	localparam int DEPTH  = MaxThumbWidth * MaxThumbHeight;
	localparam int MAXPIX = ((MaxThumbWidth + TilesX - 1) / TilesX)
		* ((MaxThumbHeight + TilesY - 1) / TilesY);
	localparam int CNTW   = $clog2(MAXPIX + 1);
	localparam int SUMW   = $clog2(MAXPIX * 765 + 1);
	localparam int DW     = SUMW + 8;
	localparam int VW     = CNTW + 2;

	state_t            state_q, state_d;
	logic [SIZE_W-1:0] thumb_width_q, thumb_height_q;
	logic [THR_W-1:0]  dup_threshold_q;
	logic              hist_q;
	logic [COLW-1:0]   col_q;
	logic [ROWW-1:0]   row_q;
	logic [TW-1:0]     walk_q;
	logic [15:0]       max_q;
	logic              out_valid_q;
	result_t           out_data_q;

	logic [CW-1:0]     w;
	logic [RW-1:0]     h;
	logic [TXW-1:0]    tx;
	logic [TYW-1:0]    ty;
	logic [TW-1:0]     tile_idx;
	logic [AW-1:0]     addr;
	logic              acc;
	logic              last_col, last_row;
	logic              size_wr;
	logic              walk_rd, div_start, load_out, clr;
	logic              walk_last;
	logic [DIFF_W-1:0] diff;
	logic [CNTW-1:0]   rd_cnt;
	logic [SUMW-1:0]   rd_sum;
	logic              div_done;
	logic [DW-1:0]     quot;
	logic [15:0]       avg;
	logic [VW-1:0]     samples;

	// effective size, out-of-range values clamped
	always_comb begin
		if (thumb_width_q == '0) begin
			w = CW'(1);
		end else if (32'(thumb_width_q) > MaxThumbWidth) begin
			w = CW'(MaxThumbWidth);
		end else begin
			w = CW'(thumb_width_q);
		end
		if (thumb_height_q == '0) begin
			h = RW'(1);
		end else if (32'(thumb_height_q) > MaxThumbHeight) begin
			h = RW'(MaxThumbHeight);
		end else begin
			h = RW'(thumb_height_q);
		end
	end

	// tile = number of edges floor(w*t/TilesX) at or below col
	always_comb begin
		tx = '0;
		for (int t = 1; t < TilesX; t++) begin
			if (32'(w) * 32'(t) < (32'(col_q) + 32'd1) * 32'(TilesX)) begin
				tx = tx + TXW'(1);
			end
		end
		ty = '0;
		for (int t = 1; t < TilesY; t++) begin
			if (32'(h) * 32'(t) < (32'(row_q) + 32'd1) * 32'(TilesY)) begin
				ty = ty + TYW'(1);
			end
		end
		tile_idx = TW'(ty) * TW'(TilesX) + TW'(tx);
	end

	assign addr     = AW'(row_q) * AW'(MaxThumbWidth) + AW'(col_q);
	assign acc      = in_valid && in_ready;
	assign last_col = (CW'(col_q) + CW'(1)) == w;
	assign last_row = (RW'(row_q) + RW'(1)) == h;
	assign size_wr  = cfg_we && (cfg_index == REG_THUMB_WIDTH || cfg_index == REG_THUMB_HEIGHT);
	assign walk_last = walk_q == TW'(NT - 1);
	assign samples  = VW'({rd_cnt, 1'b0}) + VW'(rd_cnt);
	assign avg      = (|quot[DW-1:16]) ? 16'hFFFF : quot[15:0];

	tfcd_diff #(.AW(AW), .DEPTH(DEPTH)) u_diff (
		.clk  (clk),
		.we   (acc),
		.addr (addr),
		.pix  (in_data),
		.diff (diff)
	);

	tfcd_tile #(.NT(NT), .TW(TW), .CNTW(CNTW), .SUMW(SUMW)) u_tile (
		.clk      (clk),
		.arst_n   (arst_n),
		.clr      (clr),
		.acc_en   (acc && hist_q),
		.acc_idx  (tile_idx),
		.diff     (diff),
		.walk_rd  (walk_rd),
		.walk_idx (walk_q),
		.rd_cnt   (rd_cnt),
		.rd_sum   (rd_sum)
	);

	tfcd_div #(.DW(DW), .VW(VW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({rd_sum, 8'd0}),
		.divisor  (samples),
		.done     (div_done),
		.quotient (quot)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_RUN:   if (acc && last_col && last_row) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_RD;
			ST_RD:    state_d = ST_LD;
			ST_LD: begin
				if (rd_cnt != '0) begin
					state_d = ST_DIV;
				end else begin
					state_d = walk_last ? ST_DONE : ST_RD;
				end
			end
			ST_DIV:   if (div_done) state_d = walk_last ? ST_DONE : ST_RD;
			ST_DONE:  if (!out_valid_q || out_ready) state_d = ST_RUN;
			default:  state_d = ST_RUN;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready  = state_q == ST_RUN;
		walk_rd   = state_q == ST_RD;
		div_start = state_q == ST_LD && rd_cnt != '0;
		load_out  = state_q == ST_DONE && (!out_valid_q || out_ready);
		clr       = load_out || size_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_RUN;
			thumb_width_q   <= THUMB_WIDTH_RST;
			thumb_height_q  <= THUMB_HEIGHT_RST;
			dup_threshold_q <= DUP_THRESHOLD_RST;
			hist_q          <= 1'b0;
			col_q           <= '0;
			row_q           <= '0;
			walk_q          <= '0;
			max_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_index)
					REG_THUMB_WIDTH:   thumb_width_q   <= cfg_wdata[SIZE_W-1:0];
					REG_THUMB_HEIGHT:  thumb_height_q  <= cfg_wdata[SIZE_W-1:0];
					REG_DUP_THRESHOLD: dup_threshold_q <= cfg_wdata[THR_W-1:0];
					default: ;
				endcase
			end
			if (size_wr) begin
				hist_q <= 1'b0;
				col_q  <= '0;
				row_q  <= '0;
			end else if (acc) begin
				if (!last_col) begin
					col_q <= col_q + COLW'(1);
				end else begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + ROWW'(1);
				end
			end
			if (state_q == ST_DRAIN) begin
				walk_q <= '0;
				max_q  <= '0;
			end
			if ((state_q == ST_LD && rd_cnt == '0) || (state_q == ST_DIV && div_done)) begin
				walk_q <= walk_q + TW'(1);
			end
			if (state_q == ST_DIV && div_done && avg > max_q) begin
				max_q <= avg;
			end
			if (load_out) begin
				hist_q      <= 1'b1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q.was_compared  <= hist_q;
			out_data_q.is_duplicate  <= hist_q && max_q <= dup_threshold_q;
			out_data_q.max_tile_diff <= hist_q ? max_q : 16'd0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* design/tfcd_diff.sv */
// ----------------------------------------------------------------------------
// tfcd_diff
// Previous-frame pixel store. Reads the old pixel and writes the new one in
// the same cycle; gives the sum of absolute channel differences in the next cycle.
// ----------------------------------------------------------------------------
module tfcd_diff #(
	parameter int AW    = 12,
	parameter int DEPTH = 4096
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         addr,
	input  tfcd_pkg::pixel_t      pix,
	output logic [tfcd_pkg::DIFF_W-1:0] diff
);
	import tfcd_pkg::*;

	logic [23:0] mem [DEPTH];
	logic [23:0] old_s1;
	pixel_t      pix_s1;
	pixel_t      old_px;
	logic [7:0]  dr, dg, db;

	// read returns the pre-write contents
	always_ff @(posedge clk) begin
		if (we) begin
			old_s1    <= mem[addr];
			mem[addr] <= pix;
			pix_s1    <= pix;
		end
	end

	always_comb begin
		old_px = pixel_t'(old_s1);
		dr = (pix_s1.red > old_px.red) ? pix_s1.red - old_px.red : old_px.red - pix_s1.red;
		dg = (pix_s1.green > old_px.green) ? pix_s1.green - old_px.green
			: old_px.green - pix_s1.green;
		db = (pix_s1.blue > old_px.blue) ? pix_s1.blue - old_px.blue
			: old_px.blue - pix_s1.blue;
		diff = DIFF_W'(dr) + DIFF_W'(dg) + DIFF_W'(db);
	end

endmodule

/* design/tfcd_tile.sv */
// ----------------------------------------------------------------------------
// tfcd_tile
// Tile accumulator memory: per tile a sample count and a difference sum.
// Read-modify-write with forwarding of the last write; valid bits make
// untouched tiles read as zero.
// ----------------------------------------------------------------------------
module tfcd_tile #(
	parameter int NT   = 64,
	parameter int TW   = 6,
	parameter int CNTW = 7,
	parameter int SUMW = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clr,
	input  logic                        acc_en,
	input  logic [TW-1:0]               acc_idx,
	input  logic [tfcd_pkg::DIFF_W-1:0] diff,
	input  logic                        walk_rd,
	input  logic [TW-1:0]               walk_idx,
	output logic [CNTW-1:0]             rd_cnt,
	output logic [SUMW-1:0]             rd_sum
);
	import tfcd_pkg::*;

	localparam int EW = CNTW + SUMW;

	logic [EW-1:0] mem [NT];
	logic [NT-1:0] vld_q;
	logic [EW-1:0] rd_s1;
	logic [TW-1:0] idx_s1;
	logic          en_s1;
	logic [TW-1:0] wr_idx_q;
	logic [EW-1:0] wr_val_q;
	logic          wr_vld_q;
	logic [EW-1:0] cur;
	logic [EW-1:0] nxt;
	logic [TW-1:0] rd_addr;

	assign rd_addr = acc_en ? acc_idx : walk_idx;

	always_ff @(posedge clk) begin
		if (acc_en || walk_rd) begin
			rd_s1  <= mem[rd_addr];
			idx_s1 <= rd_addr;
		end
		if (en_s1) begin
			mem[idx_s1] <= nxt;
			wr_idx_q    <= idx_s1;
			wr_val_q    <= nxt;
		end
	end

	always_comb begin
		if (wr_vld_q && wr_idx_q == idx_s1) begin
			cur = wr_val_q;
		end else if (vld_q[idx_s1]) begin
			cur = rd_s1;
		end else begin
			cur = '0;
		end
		nxt = {cur[EW-1:SUMW] + CNTW'(1), cur[SUMW-1:0] + SUMW'(diff)};
	end

	assign rd_cnt = cur[EW-1:SUMW];
	assign rd_sum = cur[SUMW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1    <= 1'b0;
			vld_q    <= '0;
			wr_vld_q <= 1'b0;
		end else begin
			en_s1 <= acc_en;
			if (clr) begin
				vld_q    <= '0;
				wr_vld_q <= 1'b0;
			end else if (en_s1) begin
				vld_q[idx_s1] <= 1'b1;
				wr_vld_q      <= 1'b1;
			end
		end
	end

endmodule

/* design/tfcd_div.sv */
// ----------------------------------------------------------------------------
// tfcd_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tfcd_div #(
	parameter int DW = 24,
	parameter int VW = 9
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	import tfcd_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   rem_sh;
	logic [VW:0]   rem_sub;
	logic          ge;

	always_comb begin
		rem_sh  = {rem_q, q_q[DW-1]};
		ge      = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			q_q   <= {q_q[DW-2:0], ge};
			rem_q <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= run_q && cnt_q == CW'(1);
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule
